// ===== rtl/pres_rpt_pkg.sv =====
`default_nettype none
package pres_rpt_pkg;

  localparam int unsigned CfgW = 16;
  localparam int unsigned TimeW = 32;

  // Configuration register indexes.
  localparam logic [7:0] CFG_REFRESH = 8'd0;
  localparam logic [7:0] CFG_HOLD    = 8'd1;

  localparam logic [CfgW-1:0] RESET_REFRESH_MS = 16'd500;
  localparam logic [CfgW-1:0] RESET_HOLD_MS    = 16'd2000;

  // Last reported state of a channel.
  localparam logic [1:0] ST_UNKNOWN = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_IDLE    = 2'd2;

  typedef struct packed {
    logic emit;
    logic present;
  } lane_res_t;

endpackage
`default_nettype wire

// ===== rtl/pres_rpt_lane.sv =====
`default_nettype none
module pres_rpt_lane
  import pres_rpt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic             idle_i,
  input  wire logic [TimeW-1:0] now_i,
  input  wire logic             refresh_i,
  input  wire logic [CfgW-1:0]  hold_i,
  output lane_res_t             res_o
);

  logic [1:0]       state_q, state_d;
  logic             run_q, run_d;
  logic [TimeW-1:0] start_q, start_d;
  logic [TimeW-1:0] elapsed;

  assign elapsed = now_i - start_q;

  always_comb begin
    state_d = state_q;
    run_d   = run_q;
    start_d = start_q;
    res_o   = '0;
    if (!idle_i) begin
      res_o.present = 1'b1;
      if ((state_q != ST_PRESENT) || refresh_i) begin
        res_o.emit = 1'b1;
        state_d    = ST_PRESENT;
      end
      run_d = 1'b0;
    end else if (!run_q) begin
      // The poll that starts the idle timer never reports.
      run_d   = 1'b1;
      start_d = now_i;
    end else if ((elapsed >= {{(TimeW-CfgW){1'b0}}, hold_i}) && (state_q != ST_IDLE)) begin
      res_o.emit = 1'b1;
      state_d    = ST_IDLE;
    end else if (refresh_i && (state_q == ST_IDLE)) begin
      res_o.emit = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_UNKNOWN;
      run_q   <= 1'b0;
    end else if (accept_i) begin
      state_q <= state_d;
      run_q   <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      start_q <= start_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pres_rpt_merge.sv =====
`default_nettype none
module pres_rpt_merge
  import pres_rpt_pkg::*;
#(
  parameter int unsigned NumLanes = 5,
  parameter int unsigned ChW = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire logic [NumLanes-1:0] mask_i,
  input  wire logic [NumLanes-1:0] pres_i,
  output logic                     free_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [ChW-1:0]           channel_o,
  output logic                     present_o,
  output logic                     last_o
);

  logic                bv_q, bv_d;
  logic [NumLanes-1:0] mask_q, mask_d;
  logic [NumLanes-1:0] pres_q, pres_d;
  logic                ov_q, ov_d;
  logic [ChW-1:0]      ch_q, ch_d;
  logic                prs_q, prs_d;
  logic                last_q, last_d;
  logic                pop;
  logic [NumLanes-1:0] low_bit;
  logic [NumLanes-1:0] rest;
  logic [ChW-1:0]      idx;

  // Lowest pending channel goes out first.
  assign low_bit = mask_q & (~mask_q + NumLanes'(1));
  assign rest    = mask_q & ~low_bit;

  always_comb begin
    idx = '0;
    for (int i = NumLanes - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        idx = ChW'(i);
      end
    end
  end

  assign pop    = bv_q && (!ov_q || out_ready_i);
  assign free_o = !bv_q || (pop && (rest == '0));

  always_comb begin
    bv_d   = bv_q;
    mask_d = mask_q;
    pres_d = pres_q;
    ov_d   = ov_q;
    ch_d   = ch_q;
    prs_d  = prs_q;
    last_d = last_q;
    if (pop) begin
      ov_d   = 1'b1;
      ch_d   = idx;
      prs_d  = pres_q[idx];
      last_d = (rest == '0);
      mask_d = rest;
      if (rest == '0) begin
        bv_d = 1'b0;
      end
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
    if (load_i) begin
      bv_d   = 1'b1;
      mask_d = mask_i;
      pres_d = pres_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      bv_q <= bv_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    pres_q <= pres_d;
    ch_q   <= ch_d;
    prs_q  <= prs_d;
    last_q <= last_d;
  end

  assign out_valid_o = ov_q;
  assign channel_o   = ch_q;
  assign present_o   = prs_q;
  assign last_o      = last_q;

  a_batch_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bv_q |-> (mask_q != '0))
    else $error("pending batch with no channels");

  a_pop_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> ov_q)
    else $error("popped report did not reach the output");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (rest == '0) && !load_i) |=> !bv_q)
    else $error("batch still pending after its last report");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bv_q && !pop) |-> !load_i)
    else $error("batch overwritten while pending");

endmodule
`default_nettype wire

// ===== rtl/presence_report_with_off_delay_unit.sv =====
// Presence reporter with idle off-delay and periodic refresh. Each input beat is one poll:
// a millisecond timestamp and one active-low level per sensor. One lane per sensor
// evaluates its channel in the cycle the poll is accepted; the reports found are then sent
// one per cycle unless out_ready_i holds the output, lowest channel first, with last_report_o
// set on the final one of the poll. A poll yields at most NUM_SENSORS reports, and the next
// poll is accepted in the cycle its predecessor's last report is moved to the output register;
// a poll with no reports loads no batch. Configuration: index 0 sets the refresh interval,
// index 1 the idle hold time, both in milliseconds; other indexes are ignored.
`default_nettype none
module presence_report_with_off_delay_unit
  import pres_rpt_pkg::*;
#(
  parameter int unsigned NUM_SENSORS = 5
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [7:0]             cfg_idx_i,
  input  wire logic [CfgW-1:0]        cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [TimeW-1:0]       now_ms_i,
  input  wire logic [NUM_SENSORS-1:0] levels_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [((NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1)-1:0] channel_o,
  output logic                        present_o,
  output logic                        last_report_o
);

  localparam int unsigned ChW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  logic [CfgW-1:0]        refresh_ms_q;
  logic [CfgW-1:0]        hold_ms_q;
  logic [TimeW-1:0]       last_refresh_q;
  logic [TimeW-1:0]       since_refresh;
  logic                   refresh;
  logic                   accept;
  logic                   free;
  lane_res_t              lane_res [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] emit_mask;
  logic [NUM_SENSORS-1:0] pres_bits;

  assign since_refresh = now_ms_i - last_refresh_q;
  assign refresh       = since_refresh >= {{(TimeW-CfgW){1'b0}}, refresh_ms_q};
  assign accept        = in_valid_i && free;
  assign in_ready_o    = free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_ms_q   <= RESET_REFRESH_MS;
      hold_ms_q      <= RESET_HOLD_MS;
      last_refresh_q <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_REFRESH)) begin
        refresh_ms_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == CFG_HOLD)) begin
        hold_ms_q <= cfg_wdata_i;
      end
      if (accept && refresh) begin
        last_refresh_q <= now_ms_i;
      end
    end
  end

  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
    pres_rpt_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .accept_i  (accept),
      .idle_i    (levels_i[g]),
      .now_i     (now_ms_i),
      .refresh_i (refresh),
      .hold_i    (hold_ms_q),
      .res_o     (lane_res[g])
    );
    assign emit_mask[g] = lane_res[g].emit;
    assign pres_bits[g] = lane_res[g].present;
  end

  pres_rpt_merge #(
    .NumLanes (NUM_SENSORS),
    .ChW      (ChW)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && (emit_mask != '0)),
    .mask_i      (emit_mask),
    .pres_i      (pres_bits),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .channel_o   (channel_o),
    .present_o   (present_o),
    .last_o      (last_report_o)
  );

endmodule
`default_nettype wire

// ===== bench/tb_presence_report_with_off_delay_unit.sv =====
`timescale 1ns / 100ps
module tb_presence_report_with_off_delay_unit;
  import pres_rpt_pkg::*;

  localparam int unsigned NSENS = 5;
  localparam int unsigned ChW = 3;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned HoldOffCycles = 300;

  // Indexes that name no register; writes to them must change nothing.
  localparam logic [7:0] CFG_UNUSED = 8'd2;
  localparam logic [7:0] CFG_TOP    = 8'hFF;

  typedef struct packed {
    logic [ChW-1:0] channel;
    logic           present;
    logic           last_report;
  } report_t;

  class report_scoreboard;
    logic [CfgW-1:0]  refresh_ms;
    logic [CfgW-1:0]  hold_ms;
    logic [1:0]       last_state [NSENS];
    logic [TimeW-1:0] idle_since [NSENS];
    bit               idle_timing [NSENS];
    logic [TimeW-1:0] last_refresh;
    report_t          reports_due [$];
    int               n_polls;
    int               n_reports;
    int               n_absent;
    int               n_repeats;
    int               n_errors;

    function new();
      refresh_ms = RESET_REFRESH_MS;
      hold_ms = RESET_HOLD_MS;
      last_refresh = '0;
      for (int ch = 0; ch < NSENS; ch++) begin
        last_state[ch] = ST_UNKNOWN;
        idle_since[ch] = '0;
        idle_timing[ch] = 1'b0;
      end
    endfunction

    function void set_reg(logic [7:0] idx, logic [CfgW-1:0] data);
      if (idx == CFG_REFRESH) begin
        refresh_ms = data;
      end else if (idx == CFG_HOLD) begin
        hold_ms = data;
      end
    endfunction

    function int pending();
      return reports_due.size();
    endfunction

    // Works out the reports that one accepted poll causes, in channel order.
    function void note_poll(logic [TimeW-1:0] now, logic [NSENS-1:0] levels);
      report_t          batch [$];
      logic [TimeW-1:0] since_refresh;
      logic [TimeW-1:0] idle_for;
      bit               refresh_due;
      since_refresh = now - last_refresh;
      refresh_due = since_refresh >= refresh_ms;
      n_polls++;
      for (int ch = 0; ch < NSENS; ch++) begin
        idle_for = now - idle_since[ch];
        if (!levels[ch]) begin
          if (last_state[ch] != ST_PRESENT || refresh_due) begin
            batch.insert(batch.size(),
                         report_t'{channel: ChW'(ch), present: 1'b1, last_report: 1'b0});
            last_state[ch] = ST_PRESENT;
          end
          idle_timing[ch] = 1'b0;
          idle_since[ch] = '0;
        end else if (!idle_timing[ch]) begin
          // The poll that starts the timer stays silent for this channel.
          idle_timing[ch] = 1'b1;
          idle_since[ch] = now;
        end else if (idle_for >= hold_ms && last_state[ch] != ST_IDLE) begin
          batch.insert(batch.size(),
                       report_t'{channel: ChW'(ch), present: 1'b0, last_report: 1'b0});
          last_state[ch] = ST_IDLE;
          n_absent++;
        end else if (refresh_due && last_state[ch] == ST_IDLE) begin
          batch.insert(batch.size(),
                       report_t'{channel: ChW'(ch), present: 1'b0, last_report: 1'b0});
          n_repeats++;
        end
      end
      if (refresh_due) begin
        last_refresh = now;
      end
      if (batch.size() > 0) begin
        batch[batch.size()-1].last_report = 1'b1;
      end
      foreach (batch[k]) begin
        reports_due.insert(reports_due.size(), batch[k]);
      end
    endfunction

    function void check_report(logic [ChW-1:0] channel, logic present, logic last_report);
      report_t want;
      n_reports++;
      if (reports_due.size() == 0) begin
        $error("report on channel %0d arrived with none due", channel);
        n_errors++;
        return;
      end
      want = reports_due.pop_front();
      if (channel !== want.channel) begin
        $error("channel: expected %0d, got %0d", want.channel, channel);
        n_errors++;
      end
      if (present !== want.present) begin
        $error("present: expected %0d, got %0d", want.present, present);
        n_errors++;
      end
      if (last_report !== want.last_report) begin
        $error("last_report: expected %0d, got %0d", want.last_report, last_report);
        n_errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [7:0]       cfg_idx_i = '0;
  logic [CfgW-1:0]  cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [TimeW-1:0] now_ms_i = '0;
  logic [NSENS-1:0] levels_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [ChW-1:0]   channel_o;
  logic             present_o;
  logic             last_report_o;

  report_scoreboard sb;
  int quiet_cycles = 0;
  int rx_hold_off = 0;
  int n_settings = 1;
  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;

  presence_report_with_off_delay_unit #(
    .NUM_SENSORS(NSENS)
  ) DUT (.*);

  always #5 clk_i = ~clk_i;

  // Mostly back to back, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_poll(input logic [TimeW-1:0] t, input logic [NSENS-1:0] lv);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    now_ms_i <= t;
    levels_i <= lv;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_poll(t, lv);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  // A poll may cause no report, so the unit gets a few extra cycles after the
  // last report before its registers change.
  task automatic program_regs(input logic [CfgW-1:0] refresh, input logic [CfgW-1:0] hold,
                              input bit stray);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (stray) begin
      write_reg(CFG_UNUSED, 16'($urandom()));
      write_reg(CFG_TOP, 16'hFFFF);
    end
    write_reg(CFG_REFRESH, refresh);
    write_reg(CFG_HOLD, hold);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Sensors flip now and then while time moves forward, so idle spells last
  // long enough to reach the hold time; a few polls jump to random values.
  task automatic random_polls(input int count, input logic [TimeW-1:0] start, input int step_max);
    logic [TimeW-1:0] t;
    logic [NSENS-1:0] lv;
    t = start;
    lv = NSENS'($urandom());
    repeat (count) begin
      if ($urandom_range(0, 99) < 6) begin
        t = $urandom();
        lv = NSENS'($urandom());
      end else begin
        t = t + $urandom_range(0, step_max);
        for (int b = 0; b < NSENS; b++) begin
          if ($urandom_range(0, 7) == 0) lv[b] = ~lv[b];
        end
      end
      send_poll(t, lv);
    end
  endtask

  initial begin : receiver
    int stall;
    forever begin
      @(posedge clk_i);
      if (rx_hold_off > 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_hold_off) @(posedge clk_i);
        rx_hold_off = 0;
        out_ready_i <= 1'b1;
      end else begin
        stall = rx_stalls ? pick_gap() : 0;
        if (stall == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          repeat (stall - 1) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_report(channel_o, present_o, last_report_o);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("presence_report_with_off_delay_unit test failed");
      $finish;
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset timing: first detection, idle timer started at time zero,
    // hold boundary, refresh repeats and a timestamp wrap.
    send_poll(32'd0, 5'b00000);
    send_poll(32'd0, 5'b11111);
    send_poll(32'd1999, 5'b11111);
    send_poll(32'd2000, 5'b11111);
    send_poll(32'd2499, 5'b01010);
    send_poll(32'd2500, 5'b10101);
    send_poll(32'hFFFF_FFFF, 5'b10101);
    send_poll(32'd0, 5'b11111);

    // Zero interval refreshes on every poll; zero hold reports absence on
    // the second idle poll.
    program_regs(16'd0, 16'd0, 1'b1);
    send_poll(32'd100, 5'b00000);
    send_poll(32'd100, 5'b00000);
    send_poll(32'd101, 5'b11111);
    send_poll(32'd101, 5'b11111);
    send_poll(32'd101, 5'b11111);
    send_poll(32'd7, 5'b01101);

    program_regs(16'hFFFF, 16'hFFFF, 1'b0);
    send_poll(32'hFFFF_FFF0, 5'b11111);
    send_poll(32'h0000_FFEE, 5'b11111);
    send_poll(32'h0000_FFEF, 5'b11111);
    send_poll(32'h0000_FFEF, 5'b00000);

    program_regs(16'd20, 16'd50, 1'b0);
    random_polls(90, $urandom(), 15);
    program_regs(16'd1, 16'd3, 1'b0);
    random_polls(50, $urandom(), 3);

    // The receiver stops for a long while so the unit backs up into its input.
    program_regs(16'($urandom_range(5, 40)), 16'($urandom_range(10, 100)), 1'b0);
    rx_hold_off = HoldOffCycles;
    random_polls(50, $urandom(), 20);

    program_regs(16'd10, 16'd25, 1'b0);
    random_polls(30, 32'hFFFF_FF00, 12);
    program_regs(16'd0, 16'd0, 1'b1);
    random_polls(30, $urandom(), 5);

    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    program_regs(16'd7, 16'd15, 1'b0);
    random_polls(30, $urandom(), 8);
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;

    program_regs(16'($urandom_range(20000, 65535)), 16'($urandom_range(30000, 65535)), 1'b0);
    random_polls(30, $urandom(), 40000);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d polls under %0d register settings and checked %0d reports,",
             sb.n_polls, n_settings, sb.n_reports);
    $display("%0d of them absence reports and %0d idle repeats forced by refresh.",
             sb.n_absent, sb.n_repeats);
    if (sb.n_errors == 0) begin
      $display("presence_report_with_off_delay_unit test passed");
    end else begin
      $display("presence_report_with_off_delay_unit test failed");
    end
    $finish;
  end

endmodule

// ===== presence_report_with_off_delay_unit.f =====
rtl/pres_rpt_pkg.sv
rtl/pres_rpt_lane.sv
rtl/pres_rpt_merge.sv
rtl/presence_report_with_off_delay_unit.sv
bench/tb_presence_report_with_off_delay_unit.sv
